// ===== src/bcts_pkg.sv =====
// ----------------------------------------------------------------------------
// bcts_pkg
// Shared types and constants of the box collision table scanner.
// ----------------------------------------------------------------------------
package bcts_pkg;

  localparam int MODE_BITS     = 2;
  localparam int SLOT_BITS     = 5;
  localparam int POS_BITS      = 16;
  localparam int SIZE_BITS     = 15;
  localparam int KIND_BITS     = 5;
  localparam int EV_BITS       = 2;

  localparam int KIND_COUNT    = 18;
  localparam int ROW_BITS      = 18;
  localparam int REG_COUNT     = 6;
  localparam int REG_BITS      = 54;
  localparam int CFG_IDX_BITS  = 3;
  localparam int RULE_BITS     = REG_COUNT * REG_BITS;
  localparam int RULE_IDX_BITS = $clog2(RULE_BITS);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_MOVE   = 2'd2,
    MODE_SCAN   = 2'd3
  } mode_e;

  typedef enum logic [EV_BITS-1:0] {
    EV_GRANT  = 2'd0,
    EV_FULL   = 2'd1,
    EV_NOTICE = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_SELF,
    ST_SCAN_CMP,
    ST_FLUSH
  } state_e;

  // Per-slot attributes that a move leaves untouched.
  typedef struct packed {
    logic                 notify;
    logic [KIND_BITS-1:0] kind;
    logic [SIZE_BITS-1:0] h;
    logic [SIZE_BITS-1:0] w;
  } attr_t;

  localparam int ATTR_BITS = $bits(attr_t);

  // Which sides of a tested pair get a notice.
  typedef struct packed {
    logic self_side;
    logic other_side;
  } pair_hit_t;

endpackage

// ===== src/bcts_ram.sv =====
// ----------------------------------------------------------------------------
// bcts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bcts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bcts_pair_check.sv =====
// ----------------------------------------------------------------------------
// bcts_pair_check
// Strict overlap test of two boxes and rule lookup for both sides.
// ----------------------------------------------------------------------------
module bcts_pair_check #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]             self_left_i,
  input  logic [COORD_BITS-1:0]             self_top_i,
  input  bcts_pkg::attr_t                   self_attr_i,
  input  logic [COORD_BITS-1:0]             other_left_i,
  input  logic [COORD_BITS-1:0]             other_top_i,
  input  bcts_pkg::attr_t                   other_attr_i,
  input  logic                              other_used_i,
  input  logic [bcts_pkg::RULE_BITS-1:0]    rules_i,
  output bcts_pkg::pair_hit_t               hit_o
);

  // wide enough that edge plus size never wraps
  localparam int EW = COORD_BITS + 17;
  localparam int ZW = EW - bcts_pkg::SIZE_BITS;

  logic signed [EW-1:0] sl, st, sw, sh, ol, ot, ow, oh;
  logic signed [EW-1:0] s_right, s_bottom, o_right, o_bottom;
  logic                 overlap;
  logic [bcts_pkg::RULE_IDX_BITS-1:0] idx_so, idx_os;
  logic                 kinds_ok, rule_so, rule_os;

  assign sl = {{17{self_left_i[COORD_BITS-1]}}, self_left_i};
  assign st = {{17{self_top_i[COORD_BITS-1]}}, self_top_i};
  assign ol = {{17{other_left_i[COORD_BITS-1]}}, other_left_i};
  assign ot = {{17{other_top_i[COORD_BITS-1]}}, other_top_i};
  assign sw = {{ZW{1'b0}}, self_attr_i.w};
  assign sh = {{ZW{1'b0}}, self_attr_i.h};
  assign ow = {{ZW{1'b0}}, other_attr_i.w};
  assign oh = {{ZW{1'b0}}, other_attr_i.h};

  assign s_right  = sl + sw;
  assign s_bottom = st + sh;
  assign o_right  = ol + ow;
  assign o_bottom = ot + oh;

  assign overlap = (sl < o_right) && (s_right > ol) && (st < o_bottom) && (s_bottom > ot);

  // row of receiver kind r starts at bit ROW_BITS * r of the flat matrix
  assign idx_so = bcts_pkg::RULE_IDX_BITS'(self_attr_i.kind)
                * bcts_pkg::RULE_IDX_BITS'(bcts_pkg::ROW_BITS)
                + bcts_pkg::RULE_IDX_BITS'(other_attr_i.kind);
  assign idx_os = bcts_pkg::RULE_IDX_BITS'(other_attr_i.kind)
                * bcts_pkg::RULE_IDX_BITS'(bcts_pkg::ROW_BITS)
                + bcts_pkg::RULE_IDX_BITS'(self_attr_i.kind);

  // unknown kinds on either side never match
  assign kinds_ok = (self_attr_i.kind < bcts_pkg::KIND_BITS'(bcts_pkg::KIND_COUNT))
                 && (other_attr_i.kind < bcts_pkg::KIND_BITS'(bcts_pkg::KIND_COUNT));
  assign rule_so  = kinds_ok && rules_i[idx_so];
  assign rule_os  = kinds_ok && rules_i[idx_os];

  assign hit_o.self_side  = other_used_i && overlap && self_attr_i.notify && rule_so;
  assign hit_o.other_side = other_used_i && overlap && other_attr_i.notify && rule_os;

endmodule

// ===== src/box_collision_table_scanner_top.sv =====
// ----------------------------------------------------------------------------
// box_collision_table_scanner_top
// Table of axis-aligned boxes with add, remove, move and pairwise scan.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write the six rule words through cfg_valid_i/cfg_ready_o
//   (ready is always high) while the block is idle. Indexes above five are
//   dropped.
//   Input channel: an item is taken when in_valid_i is high and in_stall_o
//   is low. One item is worked on at a time; in_stall_o is high until it is
//   finished.
//   Remove and move finish in the accept cycle. Add goes first to the hold
//   register, and its single result is loaded into the output register from
//   the flush state once the output is free.
//   Scan of slot s does one read of slot s, then one table read per later
//   slot, with a second step on a pair that notifies both sides and a flush
//   step to drain the last notice. The single-port read of the box memories
//   sets this loop.
//   Output channel: results leave from a register; while out_stall_i is high
//   the result holds, one more result waits in the hold register and the
//   scan stops at the notice after that.
//   Reset: all slots free, rule words cleared; box memories need no clearing
//   since the words of free slots are masked by their used flags.
// ----------------------------------------------------------------------------
module box_collision_table_scanner_top #(
  parameter int SLOTS      = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bcts_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [bcts_pkg::REG_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bcts_pkg::MODE_BITS-1:0]       mode_i,
  input  logic [bcts_pkg::SLOT_BITS-1:0]       slot_i,
  input  logic signed [bcts_pkg::POS_BITS-1:0] pos_x_i,
  input  logic signed [bcts_pkg::POS_BITS-1:0] pos_y_i,
  input  logic [bcts_pkg::SIZE_BITS-1:0]       box_width_i,
  input  logic [bcts_pkg::SIZE_BITS-1:0]       box_height_i,
  input  logic [bcts_pkg::KIND_BITS-1:0]       collider_kind_i,
  input  logic                                 has_receiver_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bcts_pkg::EV_BITS-1:0]         event_res_o,
  output logic [bcts_pkg::SLOT_BITS-1:0]       receiver_slot_o,
  output logic [bcts_pkg::SLOT_BITS-1:0]       other_slot_o,
  output logic                                 last_o
);

  localparam int SW     = $clog2(SLOTS);
  localparam int POS_W  = 2 * COORD_BITS;
  localparam int EXT_W  = bcts_pkg::POS_BITS + 32;
  localparam int SB     = bcts_pkg::SLOT_BITS;

  // ---------------- configuration ----------------
  logic [bcts_pkg::REG_BITS-1:0]  rule_q [bcts_pkg::REG_COUNT];
  logic [bcts_pkg::RULE_BITS-1:0] rule_flat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < bcts_pkg::REG_COUNT; r++) begin
        rule_q[r] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o
                 && (cfg_index_i < bcts_pkg::CFG_IDX_BITS'(bcts_pkg::REG_COUNT))) begin
      rule_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < bcts_pkg::REG_COUNT; r++) begin
      rule_flat[r*bcts_pkg::REG_BITS +: bcts_pkg::REG_BITS] = rule_q[r];
    end
  end

  // ---------------- input decode ----------------
  logic [EXT_W-1:0]      x_ext, y_ext;
  logic [COORD_BITS-1:0] left_c, top_c;
  logic [SW-1:0]         slot_idx;
  logic                  slot_in_range;
  logic [SW-1:0]         free_idx;
  logic                  free_found;
  bcts_pkg::attr_t       new_attr;

  // sign-extend and wrap the position to the stored coordinate width
  assign x_ext  = {{32{pos_x_i[bcts_pkg::POS_BITS-1]}}, pos_x_i};
  assign y_ext  = {{32{pos_y_i[bcts_pkg::POS_BITS-1]}}, pos_y_i};
  assign left_c = x_ext[COORD_BITS-1:0];
  assign top_c  = y_ext[COORD_BITS-1:0];

  assign slot_idx      = slot_i[SW-1:0];
  assign slot_in_range = ((SB+1)'(slot_i) < (SB+1)'(SLOTS));

  assign new_attr.notify = has_receiver_i;
  assign new_attr.kind   = collider_kind_i;
  assign new_attr.h      = box_height_i;
  assign new_attr.w      = box_width_i;

  // ---------------- slot occupancy ----------------
  logic [SLOTS-1:0] used_q, used_d;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // ---------------- box memories ----------------
  logic                  pos_we, attr_we, ram_re;
  logic [SW-1:0]         ram_waddr, ram_raddr;
  logic [POS_W-1:0]      pos_wdata, pos_rdata;
  logic [bcts_pkg::ATTR_BITS-1:0] attr_rdata;
  bcts_pkg::attr_t       rd_attr;

  assign pos_wdata = {top_c, left_c};
  assign rd_attr   = bcts_pkg::attr_t'(attr_rdata);

  bcts_ram #(
    .WIDTH (POS_W),
    .DEPTH (SLOTS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (ram_waddr),
    .wdata_i (pos_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (pos_rdata)
  );

  bcts_ram #(
    .WIDTH (bcts_pkg::ATTR_BITS),
    .DEPTH (SLOTS)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (ram_waddr),
    .wdata_i (new_attr),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (attr_rdata)
  );

  // ---------------- scan datapath ----------------
  bcts_pkg::state_e      state_q, state_d;
  logic [SW-1:0]         k_q, k_d, k_next;
  logic                  a_done_q, a_done_d;
  logic [SW-1:0]         self_idx_q, self_idx_d;
  logic [COORD_BITS-1:0] self_left_q, self_left_d, self_top_q, self_top_d;
  bcts_pkg::attr_t       self_attr_q, self_attr_d;
  bcts_pkg::pair_hit_t   hit;

  assign k_next = k_q + SW'(1);

  bcts_pair_check #(
    .COORD_BITS (COORD_BITS)
  ) u_pair_check (
    .self_left_i  (self_left_q),
    .self_top_i   (self_top_q),
    .self_attr_i  (self_attr_q),
    .other_left_i (pos_rdata[COORD_BITS-1:0]),
    .other_top_i  (pos_rdata[POS_W-1:COORD_BITS]),
    .other_attr_i (rd_attr),
    .other_used_i (used_q[k_q]),
    .rules_i      (rule_flat),
    .hit_o        (hit)
  );

  // ---------------- result staging ----------------
  // The newest result waits in the hold register until the next one shows
  // whether it is the last of its item.
  logic                  hold_valid_q, hold_valid_d;
  bcts_pkg::event_e      hold_ev_q, hold_ev_d;
  logic [SB-1:0]         hold_rs_q, hold_rs_d, hold_os_q, hold_os_d;
  logic                  out_valid_q, out_valid_d;
  bcts_pkg::event_e      out_ev_q, out_ev_d;
  logic [SB-1:0]         out_rs_q, out_rs_d, out_os_q, out_os_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;
  logic                  pend_a, pend_b, take;
  logic [SB-1:0]         new_rs, new_os;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    a_done_d     = a_done_q;
    self_idx_d   = self_idx_q;
    self_left_d  = self_left_q;
    self_top_d   = self_top_q;
    self_attr_d  = self_attr_q;
    used_d       = used_q;
    hold_valid_d = hold_valid_q;
    hold_ev_d    = hold_ev_q;
    hold_rs_d    = hold_rs_q;
    hold_os_d    = hold_os_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_ev_d     = out_ev_q;
    out_rs_d     = out_rs_q;
    out_os_d     = out_os_q;
    out_last_d   = out_last_q;
    pos_we       = 1'b0;
    attr_we      = 1'b0;
    ram_waddr    = slot_idx;
    ram_re       = 1'b0;
    ram_raddr    = k_next;
    pend_a       = hit.self_side && !a_done_q;
    pend_b       = hit.other_side;
    take         = !hold_valid_q || out_free;
    new_rs       = pend_a ? SB'(self_idx_q) : SB'(k_q);
    new_os       = pend_a ? SB'(k_q) : SB'(self_idx_q);

    case (state_q)
      bcts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            bcts_pkg::MODE_ADD: begin
              hold_valid_d = 1'b1;
              hold_os_d    = '0;
              if (free_found) begin
                used_d[free_idx] = 1'b1;
                pos_we           = 1'b1;
                attr_we          = 1'b1;
                ram_waddr        = free_idx;
                hold_ev_d        = bcts_pkg::EV_GRANT;
                hold_rs_d        = SB'(free_idx);
              end else begin
                hold_ev_d = bcts_pkg::EV_FULL;
                hold_rs_d = '0;
              end
              state_d = bcts_pkg::ST_FLUSH;
            end
            bcts_pkg::MODE_REMOVE: begin
              if (slot_in_range) begin
                used_d[slot_idx] = 1'b0;
              end
            end
            bcts_pkg::MODE_MOVE: begin
              pos_we = slot_in_range && used_q[slot_idx];
            end
            bcts_pkg::MODE_SCAN: begin
              if (slot_in_range && used_q[slot_idx]) begin
                ram_re    = 1'b1;
                ram_raddr = slot_idx;
                k_d       = slot_idx;
                state_d   = bcts_pkg::ST_SCAN_SELF;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bcts_pkg::ST_SCAN_SELF: begin
        self_idx_d  = k_q;
        self_left_d = pos_rdata[COORD_BITS-1:0];
        self_top_d  = pos_rdata[POS_W-1:COORD_BITS];
        self_attr_d = rd_attr;
        a_done_d    = 1'b0;
        if (k_q == SW'(SLOTS - 1)) begin
          state_d = bcts_pkg::ST_FLUSH;
        end else begin
          ram_re  = 1'b1;
          k_d     = k_next;
          state_d = bcts_pkg::ST_SCAN_CMP;
        end
      end

      bcts_pkg::ST_SCAN_CMP: begin
        // the memory word of slot k stays on the read port until k advances
        if ((pend_a || pend_b) && !take) begin
          // hold: output full and a notice already staged
        end else begin
          if (pend_a || pend_b) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_ev_d    = hold_ev_q;
              out_rs_d    = hold_rs_q;
              out_os_d    = hold_os_q;
              out_last_d  = 1'b0;
            end
            hold_valid_d = 1'b1;
            hold_ev_d    = bcts_pkg::EV_NOTICE;
            hold_rs_d    = new_rs;
            hold_os_d    = new_os;
          end
          if (pend_a && pend_b) begin
            a_done_d = 1'b1;
          end else begin
            a_done_d = 1'b0;
            if (k_q == SW'(SLOTS - 1)) begin
              state_d = bcts_pkg::ST_FLUSH;
            end else begin
              ram_re = 1'b1;
              k_d    = k_next;
            end
          end
        end
      end

      bcts_pkg::ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = bcts_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_ev_d     = hold_ev_q;
          out_rs_d     = hold_rs_q;
          out_os_d     = hold_os_q;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = bcts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bcts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bcts_pkg::ST_IDLE;
      used_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      a_done_q     <= 1'b0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
      a_done_q     <= a_done_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    self_idx_q  <= self_idx_d;
    self_left_q <= self_left_d;
    self_top_q  <= self_top_d;
    self_attr_q <= self_attr_d;
    hold_ev_q   <= hold_ev_d;
    hold_rs_q   <= hold_rs_d;
    hold_os_q   <= hold_os_d;
    out_ev_q    <= out_ev_d;
    out_rs_q    <= out_rs_d;
    out_os_q    <= out_os_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o      = (state_q != bcts_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_ev_q;
  assign receiver_slot_o = out_rs_q;
  assign other_slot_o    = out_os_q;
  assign last_o          = out_last_q;

endmodule
